FILE: hw/rtl/pngate_pkg.sv
// Shared constants, types and helper functions for the percentile noise gate.
package pngate_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int MAG_W   = SAMPLE_BITS;
    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W   = $clog2(WINDOW_MAX);
    localparam int COUNT_W = 15;
    localparam int WLEN_W  = 7;
    localparam int EFR_W   = 8;
    localparam int CFG_W   = 8;
    localparam int LIM_W   = EFR_W + WIN_W;
    localparam int ACC_W   = SAMPLE_BITS + 16;
    localparam int DIV_W   = WIN_W + 9;

    localparam int ALPHA_Q16 = 6554;
    localparam int ALPHA_W   = 14;

    localparam logic [AGE_W-1:0]   AGE_OLDEST  = AGE_W'(WINDOW_MAX - 1);
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(32);
    localparam logic [EFR_W-1:0]   EFR_RESET   = EFR_W'(10);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

    localparam logic [0:0] CFG_WINDOW_LEN      = 1'b0;
    localparam logic [0:0] CFG_ESTIMATE_FRAMES = 1'b1;

    typedef enum logic [1:0] {
        DEC_ESTIMATE = 2'd0,
        DEC_PASS     = 2'd1,
        DEC_REPLACE  = 2'd2
    } decision_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_SELECT,
        ST_DONE
    } state_t;

    // Broadcast from the controller to every cell of the sorted chain.
    typedef struct packed {
        logic             upd;
        logic             del;
        logic [MAG_W-1:0] new_mag;
        logic [MAG_W-1:0] del_mag;
        logic             scan;
        logic [WIN_W-1:0] n;
        logic [WIN_W-1:0] k;
    } chain_ctl_t;

    // What one cell shows to its two neighbors.
    typedef struct packed {
        logic             move_up;
        logic             move_down;
        logic [MAG_W-1:0] mag;
        logic [AGE_W-1:0] age;
        logic [WIN_W-1:0] rank_fwd;
    } cell_link_t;

    function automatic logic [WIN_W-1:0] eff_window(input logic [WLEN_W-1:0] wl);
        logic [WIN_W-1:0] w;
        if (wl == '0) begin
            w = WIN_W'(1);
        end
        else if (32'(wl) > WINDOW_MAX) begin
            w = WIN_W'(WINDOW_MAX);
        end
        else begin
            w = WIN_W'(wl);
        end
        return w;
    endfunction

    // n / 10 by reciprocal multiplication; exact over the window range.
    function automatic logic [WIN_W-1:0] div10(input logic [WIN_W-1:0] n);
        logic [DIV_W-1:0] p;
        p = DIV_W'(n) * DIV_W'(205);
        return WIN_W'(p >> 11);
    endfunction

endpackage

FILE: hw/rtl/percentile_noise_gate_core.sv
// Top level of the percentile noise gate: control, amplitude ring, smoother and sorted chain.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | in_valid/in_stall  | sample_in (signed 16)
//   output   | out_valid/out_stall| sample_out (signed 16), decision (2)
//   config   | cfg_we             | cfg_index (0 window_len, 1 estimate_frames),
//            |                    | cfg_data
//
// A transaction in the gated phase steps through accept, update and result.
// During noise estimation a scan step and a select step come between update and result; the
// scan lets the rank count ripple one cell per cycle through the sorted chain.
// The result register lets the next transaction be accepted while a result
// waits; a stalled output holds the core in its result step.
// Reset is asynchronous and clears control state; no clearing pass is needed.
module percentile_noise_gate_core
    import pngate_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [1:0]                    decision,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_data
);

    state_t state_reg, state_next;

    logic [WLEN_W-1:0]  wlen_reg;
    logic [EFR_W-1:0]   efr_reg;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               est_reg;
    logic [WIN_W-1:0]   n_reg;
    logic [WIN_W-1:0]   k_reg;
    logic [AGE_W-1:0]   scan_cnt_reg;
    logic [WIN_W-1:0]   fill_reg, fill_next;
    logic [COUNT_W-1:0] count_reg;
    logic [MAG_W-1:0]   floor_reg;
    logic [MAG_W-1:0]   ring_reg [WINDOW_MAX];

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic [1:0]                    decision_reg;

    logic               accept;
    logic               upd;
    logic               scan;
    logic               sel;
    logic               out_free;
    logic               out_load;
    logic               estimating;
    logic [WIN_W-1:0]   w_eff;
    logic [LIM_W-1:0]   limit;
    logic [WIN_W-1:0]   n_now;
    logic signed [SAMPLE_BITS:0] neg_in;

    chain_ctl_t                    ctl;
    logic [MAG_W-1:0]              floor_mag;
    logic signed [SAMPLE_BITS-1:0] smooth_out;
    logic signed [SAMPLE_BITS-1:0] result_sample;
    decision_t                     result_dec;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = estimating ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == AGE_OLDEST)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine
    always_comb
    begin
        in_stall = 1'b1;
        upd      = 1'b0;
        scan     = 1'b0;
        sel      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_UPDATE: upd      = 1'b1;
            ST_SCAN:   scan     = 1'b1;
            ST_SELECT: sel      = 1'b1;
            ST_DONE:   out_load = out_free;
            default:   in_stall = 1'b1;
        endcase
    end

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        w_eff      = eff_window(wlen_reg);
        limit      = LIM_W'(efr_reg) * LIM_W'(w_eff);
        estimating = (32'(count_reg) < 32'(limit));
        fill_next  = (fill_reg == WIN_W'(WINDOW_MAX)) ? fill_reg : fill_reg + WIN_W'(1);
        n_now      = (fill_next < w_eff) ? fill_next : w_eff;
        neg_in     = -$signed({sample_in[SAMPLE_BITS-1], sample_in});
    end

    always_comb
    begin
        ctl.upd     = upd;
        ctl.del     = (fill_reg == WIN_W'(WINDOW_MAX));
        ctl.new_mag = mag_reg;
        ctl.del_mag = ring_reg[WINDOW_MAX-1];
        ctl.scan    = scan;
        ctl.n       = n_reg;
        ctl.k       = k_reg;
    end

    pngate_chain u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .fill      (fill_reg),
        .floor_mag (floor_mag)
    );

    pngate_ema u_ema (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (upd),
        .x       (x_reg),
        .rounded (smooth_out)
    );

    always_comb
    begin
        if (est_reg)
        begin
            result_sample = x_reg;
            result_dec    = DEC_ESTIMATE;
        end
        else if (mag_reg > floor_reg)
        begin
            result_sample = x_reg;
            result_dec    = DEC_PASS;
        end
        else
        begin
            result_sample = smooth_out;
            result_dec    = DEC_REPLACE;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= WLEN_RESET;
            efr_reg       <= EFR_RESET;
            fill_reg      <= '0;
            count_reg     <= '0;
            floor_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_LEN:      wlen_reg <= cfg_data[WLEN_W-1:0];
                    CFG_ESTIMATE_FRAMES: efr_reg  <= cfg_data[EFR_W-1:0];
                    default:             wlen_reg <= wlen_reg;
                endcase
            end
            if (upd)
            begin
                fill_reg <= fill_next;
                if (count_reg != COUNT_LIMIT)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
            if (sel)
            begin
                floor_reg <= floor_mag;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= sample_in;
            mag_reg <= MAG_W'(neg_in[SAMPLE_BITS-1:0] == '0 && !sample_in[SAMPLE_BITS-1]
                              ? sample_in : (sample_in[SAMPLE_BITS-1] ? neg_in : sample_in));
        end
        if (upd)
        begin
            est_reg      <= estimating;
            n_reg        <= n_now;
            k_reg        <= div10(n_now);
            scan_cnt_reg <= '0;
            ring_reg[0]  <= mag_reg;
            for (int i = 1; i < WINDOW_MAX; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
        end
        if (scan)
        begin
            scan_cnt_reg <= scan_cnt_reg + AGE_W'(1);
        end
        if (out_load)
        begin
            sample_out_reg <= result_sample;
            decision_reg   <= result_dec;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign decision   = decision_reg;

endmodule

FILE: hw/rtl/pngate_cell.sv
// One cell of the sorted amplitude chain: insert/delete shifting and rank counting.
module pngate_cell
    import pngate_pkg::*;
(
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic             valid,
    input  cell_link_t       left,
    input  cell_link_t       right,
    output cell_link_t       link,
    output logic [MAG_W-1:0] hit_mag
);

    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic [WIN_W-1:0] rank_reg, rank_next;

    logic above_del;
    logic big;
    logic gone;
    logic stay;
    logic flag;

    // Entries are ordered by magnitude, ties by age (youngest first), so the
    // dropped entry is the last of its magnitude and a new one goes first.
    always_comb
    begin
        above_del = ctl.del && valid && (mag_reg > ctl.del_mag);
        big       = !valid || (mag_reg >= ctl.new_mag);
        gone      = ctl.del && valid && (age_reg == AGE_OLDEST);
        stay      = (above_del == big) && !gone;
        flag      = valid && (age_reg < AGE_W'(ctl.n > WIN_W'(WINDOW_MAX - 1)
                                               ? WIN_W'(WINDOW_MAX - 1) : ctl.n))
                    || (valid && (ctl.n == WIN_W'(WINDOW_MAX)));

        link.move_up   = big && !above_del && !gone;
        link.move_down = above_del && !big && !gone;
        link.mag       = mag_reg;
        link.age       = age_reg;
        link.rank_fwd  = rank_reg + WIN_W'(flag);

        hit_mag = (flag && (rank_reg == ctl.k)) ? mag_reg : '0;
    end

    always_comb
    begin
        mag_next  = mag_reg;
        age_next  = age_reg;
        rank_next = rank_reg;
        if (ctl.upd)
        begin
            if (right.move_down)
            begin
                mag_next = right.mag;
                age_next = right.age + AGE_W'(1);
            end
            else if (left.move_up)
            begin
                mag_next = left.mag;
                age_next = left.age + AGE_W'(1);
            end
            else if (stay)
            begin
                age_next = age_reg + AGE_W'(1);
            end
            else
            begin
                mag_next = ctl.new_mag;
                age_next = '0;
            end
        end
        if (ctl.scan)
        begin
            rank_next = left.rank_fwd;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        age_reg  <= age_next;
        rank_reg <= rank_next;
    end

endmodule

FILE: hw/rtl/pngate_chain.sv
// Row of sorted amplitude cells and the selection of the noise floor entry.
module pngate_chain
    import pngate_pkg::*;
(
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic [WIN_W-1:0] fill,
    output logic [MAG_W-1:0] floor_mag
);

    cell_link_t       links    [WINDOW_MAX];
    logic [MAG_W-1:0] hit_mags [WINDOW_MAX];
    cell_link_t       null_link;

    assign null_link = '0;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        cell_link_t left_l;
        cell_link_t right_l;
        logic       valid_l;

        if (i == 0)
        begin : g_first
            assign left_l = null_link;
        end
        else
        begin : g_left
            assign left_l = links[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign right_l = null_link;
        end
        else
        begin : g_right
            assign right_l = links[i+1];
        end

        // Sorted entries are packed at the low end of the row.
        assign valid_l = (WIN_W'(i) < fill);

        pngate_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .valid   (valid_l),
            .left    (left_l),
            .right   (right_l),
            .link    (links[i]),
            .hit_mag (hit_mags[i])
        );
    end

    // Exactly one window entry has the wanted rank, so an OR picks it.
    always_comb
    begin
        floor_mag = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            floor_mag = floor_mag | hit_mags[i];
        end
    end

endmodule

FILE: hw/rtl/pngate_ema.sv
// Q16.16 exponential smoother of the signed samples and its rounded, clamped value.
module pngate_ema
    import pngate_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [SAMPLE_BITS-1:0] x,
    output logic signed [SAMPLE_BITS-1:0] rounded
);

    localparam int PROD_W = ACC_W + ALPHA_W + 1;

    localparam logic signed [ALPHA_W-1:0] ALPHA     = ALPHA_W'(ALPHA_Q16);
    localparam logic signed [PROD_W-1:0]  HALF_PROD = PROD_W'(32768);
    localparam logic signed [ACC_W:0]     HALF_ACC  = (ACC_W + 1)'(32768);
    localparam logic signed [ACC_W:0]     OUT_MAX   = (ACC_W + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W:0]     OUT_MIN   = -OUT_MAX - (ACC_W + 1)'(1);

    logic signed [ACC_W-1:0]  s_reg, s_next;
    logic signed [ACC_W:0]    diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step_full;
    logic signed [ACC_W:0]    round_sum;
    logic signed [ACC_W:0]    q;

    always_comb
    begin
        diff      = $signed({x[SAMPLE_BITS-1], x, 16'b0}) - $signed({s_reg[ACC_W-1], s_reg});
        prod      = diff * ALPHA;
        step_full = (prod + HALF_PROD) >>> 16;
        s_next    = en ? (s_reg + ACC_W'(step_full)) : s_reg;
    end

    // Arithmetic shift gives the floor for negative values as well.
    always_comb
    begin
        round_sum = $signed({s_reg[ACC_W-1], s_reg}) + HALF_ACC;
        q         = round_sum >>> 16;
        if (q > OUT_MAX)
        begin
            rounded = SAMPLE_BITS'(OUT_MAX);
        end
        else if (q < OUT_MIN)
        begin
            rounded = SAMPLE_BITS'(OUT_MIN);
        end
        else
        begin
            rounded = SAMPLE_BITS'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
        end
        else
        begin
            s_reg <= s_next;
        end
    end

endmodule
